@@ sv/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
// No dependencies; every other file takes names from here by scope.
package mhpq_pkg;

    localparam int CAPACITY_DEF = 127;

    localparam int DATA_W  = 8;
    localparam int PRIO_W  = 16;
    localparam int TOTAL_W = 7;

    typedef struct packed {
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_RM_LOAD,
        ST_RM_RD,
        ST_RM_CMP,
        ST_DONE
    } state_t;

endpackage

@@ sv/mhpq_ifs.sv @@
// Valid/ready channel interfaces for the queue's request and response beats.
// Depends on mhpq_pkg for field widths.
interface mhpq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [mhpq_pkg::DATA_W-1:0]         data_value;
    logic signed [mhpq_pkg::PRIO_W-1:0]  priority_req;

    modport source (output valid, operation, data_value, priority_req, input ready);
    modport sink   (input valid, operation, data_value, priority_req, output ready);
endinterface

interface mhpq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mhpq_pkg::DATA_W-1:0]  removed_data;
    logic                         removed_valid;
    logic [1:0]                   status;
    logic [mhpq_pkg::TOTAL_W-1:0] entry_total;
    logic                         is_empty;
    logic                         is_full;

    modport source (output valid, removed_data, removed_valid, status, entry_total,
                    is_empty, is_full, input ready);
    modport sink   (input valid, removed_data, removed_valid, status, entry_total,
                    is_empty, is_full, output ready);
endinterface

@@ sv/mhpq_store.sv @@
// Heap entry store: one write port, two read ports with registered data.
// Depends on mhpq_pkg for the entry type.
module mhpq_store #(
    parameter int DEPTH = mhpq_pkg::CAPACITY_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  mhpq_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output mhpq_pkg::entry_t rdata_a,
    output mhpq_pkg::entry_t rdata_b
);

    mhpq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue: sequencer, count, result register.
// Depends on mhpq_pkg, mhpq_ifs (channel interfaces) and mhpq_store.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------------
//  req     | in  | operation, data_value, priority_req
//  rsp     | out | removed_data, removed_valid, status, entry_total, is_empty, is_full
//
// One request beat is worked at a time; req.ready is high only while idle.
// Each tree level reads the parent or both children through the store's read ports,
// then compares and writes back. A rejected request (insert when full, remove when
// empty) goes straight to the result state with an error status.
// The result sits in an output register, so a new request is taken while rsp stalls;
// a finished item waits in its last state only if the previous beat is still held.
// Reset clears the count and control; the store itself is never cleared.
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    mhpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    pos_reg, pos_next;
    mhpq_pkg::entry_t item_reg, item_next;
    mhpq_pkg::entry_t last_reg, last_next;
    logic [mhpq_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic             rvalid_reg, rvalid_next;
    mhpq_pkg::status_t status_reg, status_next;

    logic             out_valid_reg;
    logic [mhpq_pkg::DATA_W-1:0]  out_data_reg;
    logic             out_rvalid_reg;
    mhpq_pkg::status_t out_status_reg;
    logic [mhpq_pkg::TOTAL_W-1:0] out_total_reg;
    logic             out_empty_reg;
    logic             out_full_reg;

    // store ports
    logic             we;
    logic [CW-1:0]    waddr;
    mhpq_pkg::entry_t wdata;
    logic [CW-1:0]    raddr_a;
    logic [CW-1:0]    raddr_b;
    mhpq_pkg::entry_t rd_a;
    mhpq_pkg::entry_t rd_b;

    logic             accept;
    logic             load_out;
    logic [CW:0]      left_idx;
    logic [CW:0]      right_idx;
    logic [CW:0]      count_ext;
    logic             take_left;
    mhpq_pkg::entry_t child;
    logic [CW-1:0]    child_idx;

    mhpq_store #(
        .DEPTH (CAPACITY + 1),
        .AW    (CW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign req.ready = (state_reg == mhpq_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Child indices of the current node, one bit wider so the right child never wraps
    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = left_idx + (CW+1)'(1);
    assign count_ext = {1'b0, count_reg};

    // Left wins only when it is the sole child or strictly greater than the right one
    assign take_left = (left_idx == count_ext) || ($signed(rd_a.prio) > $signed(rd_b.prio));
    assign child     = take_left ? rd_a : rd_b;
    assign child_idx = take_left ? left_idx[CW-1:0] : right_idx[CW-1:0];

    assign load_out  = (state_reg == mhpq_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers hold payload only
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
        rdata_reg  <= rdata_next;
        rvalid_reg <= rvalid_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        last_next   = last_reg;
        rdata_next  = rdata_reg;
        rvalid_next = rvalid_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = item_reg;
        raddr_a     = '0;
        raddr_b     = '0;

        case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next.data = req.data_value;
                    item_next.prio = req.priority_req;
                    rdata_next     = '0;
                    rvalid_next    = 1'b0;
                    status_next    = mhpq_pkg::STATUS_OK;
                    if (req.operation == mhpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::STATUS_FULL;
                            state_next  = mhpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            pos_next   = count_reg + CW'(1);
                            state_next = mhpq_pkg::ST_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next  = mhpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // fetch root and last entry together
                            raddr_a    = CW'(1);
                            raddr_b    = count_reg;
                            state_next = mhpq_pkg::ST_RM_LOAD;
                        end
                    end
                end
            end

            mhpq_pkg::ST_INS_RD:
            begin
                if (pos_reg == CW'(1))
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = mhpq_pkg::ST_DONE;
                end
                else
                begin
                    raddr_a    = pos_reg >> 1;
                    state_next = mhpq_pkg::ST_INS_CMP;
                end
            end

            mhpq_pkg::ST_INS_CMP:
            begin
                we = 1'b1;
                if ($signed(item_reg.prio) > $signed(rd_a.prio))
                begin
                    // pull the parent down and climb
                    wdata      = rd_a;
                    pos_next   = pos_reg >> 1;
                    state_next = mhpq_pkg::ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = mhpq_pkg::ST_DONE;
                end
            end

            mhpq_pkg::ST_RM_LOAD:
            begin
                rdata_next  = rd_a.data;
                rvalid_next = 1'b1;
                last_next   = rd_b;
                pos_next    = CW'(1);
                state_next  = mhpq_pkg::ST_RM_RD;
            end

            mhpq_pkg::ST_RM_RD:
            begin
                if (left_idx > count_ext)
                begin
                    we         = 1'b1;
                    wdata      = last_reg;
                    count_next = count_reg - CW'(1);
                    state_next = mhpq_pkg::ST_DONE;
                end
                else
                begin
                    raddr_a    = left_idx[CW-1:0];
                    raddr_b    = (right_idx > count_ext) ? left_idx[CW-1:0]
                                                         : right_idx[CW-1:0];
                    state_next = mhpq_pkg::ST_RM_CMP;
                end
            end

            mhpq_pkg::ST_RM_CMP:
            begin
                we = 1'b1;
                if ($signed(last_reg.prio) < $signed(child.prio))
                begin
                    // lift the child and descend
                    wdata      = child;
                    pos_next   = child_idx;
                    state_next = mhpq_pkg::ST_RM_RD;
                end
                else
                begin
                    wdata      = last_reg;
                    count_next = count_reg - CW'(1);
                    state_next = mhpq_pkg::ST_DONE;
                end
            end

            mhpq_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register: hold the beat until taken, load a new one when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg   <= rdata_reg;
            out_rvalid_reg <= rvalid_reg;
            out_status_reg <= status_reg;
            out_total_reg  <= mhpq_pkg::TOTAL_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
            out_full_reg   <= (count_reg == CW'(CAPACITY));
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_data  = out_data_reg;
    assign rsp.removed_valid = out_rvalid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_total   = out_total_reg;
    assign rsp.is_empty      = out_empty_reg;
    assign rsp.is_full       = out_full_reg;

    // The count never runs past the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // During a remove the walk stays inside the occupied part of the heap
    a_rm_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhpq_pkg::ST_RM_RD || state_reg == mhpq_pkg::ST_RM_CMP)
        |-> (pos_reg >= CW'(1) && pos_reg <= count_reg))
        else $error("sift-down position outside heap");

    // A removed entry is only reported with an ok status
    a_rm_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.removed_valid) |-> (rsp.status == mhpq_pkg::STATUS_OK))
        else $error("removed entry with error status");

    // The store is written only by the walking states
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == mhpq_pkg::ST_INS_RD || state_reg == mhpq_pkg::ST_INS_CMP ||
                state_reg == mhpq_pkg::ST_RM_RD || state_reg == mhpq_pkg::ST_RM_CMP))
        else $error("store write outside a sift");

    // The count changes by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

endmodule
